@@ src/psd_pkg.sv @@
`default_nettype none

package psd_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH  = 2'd2;
   localparam logic [1:0] CSR_IDLE_LIMIT  = 2'd3;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd170;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd85;
   localparam logic [7:0] MAX_LENGTH_RESET  = 8'd120;
   localparam logic [7:0] IDLE_LIMIT_RESET  = 8'd5;

   // Result kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_CHECKSUM = 2'd1;
   localparam logic [1:0] ERR_LENGTH   = 2'd2;
   localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_ID,
      PH_TYPE,
      PH_LEN,
      PH_DATA,
      PH_CK0,
      PH_CK1
   } phase_type;

   // A request after classification against the configuration.
   typedef struct packed {
      logic       is_tick;
      logic [7:0] data;
      logic       eq_first;
      logic       eq_second;
      logic       len_bad;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] index;
      logic [7:0] id;
      logic [7:0] pkt_type;
      logic [7:0] length;
      logic [1:0] err;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

@@ src/psd_front.sv @@
`default_nettype none

module psd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_data,
   input  wire logic             req_type,
   input  wire logic [7:0]       req_rx_byte,
   output psd_pkg::item_type     item,
   output logic [7:0]            idle_limit
);
   import psd_pkg::*;

   logic [7:0] sync_first_ff, sync_first_in;
   logic [7:0] sync_second_ff, sync_second_in;
   logic [7:0] max_length_ff, max_length_in;
   logic [7:0] idle_limit_ff, idle_limit_in;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      max_length_in  = max_length_ff;
      idle_limit_in  = idle_limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_data;
            CSR_SYNC_SECOND: sync_second_in = csr_data;
            CSR_MAX_LENGTH:  max_length_in  = csr_data;
            CSR_IDLE_LIMIT:  idle_limit_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         max_length_ff  <= MAX_LENGTH_RESET;
         idle_limit_ff  <= IDLE_LIMIT_RESET;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         max_length_ff  <= max_length_in;
         idle_limit_ff  <= idle_limit_in;
      end
   end

   // The compares are done here so the back end only has to steer on flags.
   always_comb begin
      item.is_tick   = req_type;
      item.data      = req_rx_byte;
      item.eq_first  = (req_rx_byte == sync_first_ff);
      item.eq_second = (req_rx_byte == sync_second_ff);
      item.len_bad   = (req_rx_byte == 8'd0) || item.eq_first || item.eq_second ||
                       (req_rx_byte > max_length_ff);
   end

   assign idle_limit = idle_limit_ff;

endmodule

`default_nettype wire

@@ src/psd_queue.sv @@
`default_nettype none

module psd_queue #(
   parameter int DEPTH = psd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire psd_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output psd_pkg::item_type      head_item
);
   import psd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ src/psd_back.sv @@
`default_nettype none

module psd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire psd_pkg::item_type head_item,
   output logic                   pop,
   input  wire logic [7:0]        idle_limit,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output psd_pkg::result_type    rsp
);
   import psd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_length_ff, held_length_in;
   logic [7:0]  payload_count_ff, payload_count_in;
   logic [7:0]  idle_count_ff, idle_count_in;
   logic [7:0]  first_check_ff, first_check_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic [7:0]  idle_next;
   logic        timeout;
   logic [7:0]  count_next;
   logic [7:0]  sum_low_add;
   logic [7:0]  sum_high_add;
   logic        res_valid;
   result_type  res;

   // A request is consumed whenever the output register is free or being emptied.
   assign pop = head_valid && (!out_valid_ff || !rsp_stall);

   assign idle_next    = (idle_count_ff == 8'hFF) ? 8'hFF : idle_count_ff + 8'd1;
   assign timeout      = (idle_next > idle_limit);
   assign count_next   = payload_count_ff + 8'd1;
   assign sum_low_add  = sum_low_ff + head_item.data;
   assign sum_high_add = sum_high_ff + sum_low_add;

   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         if (head_item.is_tick) begin
            if (phase_ff != PH_HUNT && timeout) begin
               phase_in = PH_HUNT;
            end
         end else begin
            case (phase_ff)
               PH_HUNT:  phase_in = head_item.eq_first ? PH_SYNC2 : PH_HUNT;
               PH_SYNC2: phase_in = head_item.eq_second ? PH_ID : PH_HUNT;
               PH_ID:    phase_in = PH_TYPE;
               PH_TYPE:  phase_in = PH_LEN;
               PH_LEN:   phase_in = head_item.len_bad ? PH_HUNT : PH_DATA;
               PH_DATA:  phase_in = (count_next >= held_length_ff) ? PH_CK0 : PH_DATA;
               PH_CK0:   phase_in = PH_CK1;
               PH_CK1:   phase_in = PH_HUNT;
               default:  phase_in = PH_HUNT;
            endcase
         end
      end
   end

   always_comb begin
      sum_low_in       = sum_low_ff;
      sum_high_in      = sum_high_ff;
      held_id_in       = held_id_ff;
      held_type_in     = held_type_ff;
      held_length_in   = held_length_ff;
      payload_count_in = payload_count_ff;
      idle_count_in    = idle_count_ff;
      first_check_in   = first_check_ff;
      res_valid        = 1'b0;
      res.kind         = KIND_REJECT;
      res.data         = 8'd0;
      res.index        = 8'd0;
      res.id           = held_id_ff;
      res.pkt_type     = held_type_ff;
      res.length       = held_length_ff;
      res.err          = ERR_NONE;
      res.last         = 1'b1;
      if (pop) begin
         if (head_item.is_tick) begin
            if (phase_ff != PH_HUNT) begin
               idle_count_in = idle_next;
               if (timeout) begin
                  idle_count_in = 8'd0;
                  // Losing the line before the second sync byte is silent.
                  res_valid     = (phase_ff != PH_SYNC2);
                  res.err       = ERR_TIMEOUT;
               end
            end
         end else begin
            idle_count_in = 8'd0;
            case (phase_ff)
               PH_HUNT: begin
                  if (head_item.eq_first) begin
                     sum_low_in       = 8'd0;
                     sum_high_in      = 8'd0;
                     held_id_in       = 8'd0;
                     held_type_in     = 8'd0;
                     held_length_in   = 8'd0;
                     payload_count_in = 8'd0;
                     first_check_in   = 8'd0;
                  end
               end
               PH_SYNC2: ;
               PH_ID: begin
                  held_id_in  = head_item.data;
                  sum_low_in  = sum_low_add;
                  sum_high_in = sum_high_add;
               end
               PH_TYPE: begin
                  held_type_in = head_item.data;
                  sum_low_in   = sum_low_add;
                  sum_high_in  = sum_high_add;
               end
               PH_LEN: begin
                  held_length_in   = head_item.data;
                  payload_count_in = 8'd0;
                  res.length       = head_item.data;
                  res_valid        = head_item.len_bad;
                  res.err          = ERR_LENGTH;
               end
               PH_DATA: begin
                  sum_low_in       = sum_low_add;
                  sum_high_in      = sum_high_add;
                  payload_count_in = count_next;
                  res_valid        = 1'b1;
                  res.kind         = KIND_DATA;
                  res.data         = head_item.data;
                  res.index        = payload_count_ff;
                  res.last         = 1'b0;
               end
               PH_CK0: begin
                  first_check_in = head_item.data;
               end
               PH_CK1: begin
                  res_valid = 1'b1;
                  if ((first_check_ff == sum_low_ff) && (head_item.data == sum_high_ff)) begin
                     res.kind = KIND_ACCEPT;
                  end else begin
                     res.err = ERR_CHECKSUM;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (pop && res_valid) begin
         out_in       = res;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         sum_low_ff       <= 8'd0;
         sum_high_ff      <= 8'd0;
         held_id_ff       <= 8'd0;
         held_type_ff     <= 8'd0;
         held_length_ff   <= 8'd0;
         payload_count_ff <= 8'd0;
         idle_count_ff    <= 8'd0;
         first_check_ff   <= 8'd0;
         out_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         sum_low_ff       <= sum_low_in;
         sum_high_ff      <= sum_high_in;
         held_id_ff       <= held_id_in;
         held_type_ff     <= held_type_in;
         held_length_ff   <= held_length_in;
         payload_count_ff <= payload_count_in;
         idle_count_ff    <= idle_count_in;
         first_check_ff   <= first_check_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   a_data_within_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> payload_count_ff < held_length_ff)
      else $error("payload count reached the length while still in the data phase");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.last == (out_ff.kind != KIND_DATA)))
      else $error("last flag does not match the result kind");

   a_error_only_on_reject: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.err != ERR_NONE |-> out_ff.kind == KIND_REJECT)
      else $error("error code on a result that is not a reject");

   a_good_length_opens_data: assert property (@(posedge clock) disable iff (reset)
      pop && !head_item.is_tick && phase_ff == PH_LEN && !head_item.len_bad
      |=> phase_ff == PH_DATA)
      else $error("valid length did not open the payload");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result was lost or overwritten");

endmodule

`default_nettype wire

@@ src/packet_stream_deframer.sv @@
`default_nettype none

// Packet stream deframer.
// The request channel carries one received byte (req_type low) or one
// millisecond idle tick (req_type high) per request. The deframer hunts for
// the two sync bytes, then reads id, type, length, payload and two check
// bytes. Every payload byte is passed on as a data result; each packet ends
// with one accept or reject result carrying last, the held header bytes and
// an error code (checksum, bad length or idle timeout).
// Configuration is written over the csr_ port with the block idle; the user
// must keep to this, as the block itself does not enforce it. Throughput is
// one request per cycle while req_stall is low. A request passes a queue of
// QUEUE_DEPTH entries (two by default) behind the classifier; once nothing
// waits ahead of it, its result is registered in the output register on rsp_.
// When rsp_stall holds a result, the back end stops taking from the queue,
// the queue fills, and req_stall rises once it is full.
// Reset returns the configuration to its defaults, empties the queue and the
// output register and puts the deframer back to hunting for a sync byte.
module packet_stream_deframer #(
   parameter int QUEUE_DEPTH = psd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_byte_index,
   output logic [7:0]       rsp_packet_id,
   output logic [7:0]       rsp_packet_type,
   output logic [7:0]       rsp_payload_length,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);
   import psd_pkg::*;

   item_type    front_item;
   item_type    head_item;
   logic [7:0]  idle_limit;
   logic        queue_full;
   logic        head_valid;
   logic        pop;
   result_type  rsp;

   psd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_type         (req_type),
      .req_rx_byte      (req_rx_byte),
      .item             (front_item),
      .idle_limit       (idle_limit)
   );

   psd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   psd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .idle_limit (idle_limit),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign req_stall          = queue_full;
   assign rsp_result_kind    = rsp.kind;
   assign rsp_data_byte      = rsp.data;
   assign rsp_byte_index     = rsp.index;
   assign rsp_packet_id      = rsp.id;
   assign rsp_packet_type    = rsp.pkt_type;
   assign rsp_payload_length = rsp.length;
   assign rsp_error_code     = rsp.err;
   assign rsp_last           = rsp.last;

endmodule

`default_nettype wire
